@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the strict priority multi-queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int NUM_PRIORITIES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF    = 16;

  localparam int CMD_W    = 2;
  localparam int TASK_W   = 16;
  localparam int PRI_W    = 3;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 8;
  localparam int PCOUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                any_waiting;
    logic [PRI_W-1:0]    front_priority;
    logic [TOTAL_W-1:0]  total_count;
    logic [PCOUNT_W-1:0] priority_count;
  } spq_status_t;

endpackage

`default_nettype wire

@@ design/strict_priority_multi_queue.sv @@
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// Set of FIFO task queues, one per priority level, served highest first.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd, task_id and priority_req with start high; the
//   transfer happens on a rising edge where start is high and busy is low.
//   cmd selects add (append task_id at priority_req), remove (drop the front
//   of the highest non-empty level) or query.
//   Result channel: done is high for exactly one cycle per command, after the
//   input register and the result register, with status, any_waiting, the
//   front task and its level, the total count and the count at priority_req,
//   all reflecting the state after the command. The receiver cannot stall.
//   Throughput: one command per cycle while busy is low; back-to-back commands
//   see each other's updates. Latency is set by the input register and the
//   registered read of the task store RAM.
//   Reset (rst, synchronous): all levels empty; busy is high for one cycle
//   after reset is released. Task store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_priority_multi_queue
  import spq_pkg::*;
#(
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [TASK_W-1:0]   task_id,
  input  wire logic [PRI_W-1:0]    priority_req,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic                     any_waiting,
  output logic [TASK_W-1:0]        front_task_id,
  output logic [PRI_W-1:0]         front_priority,
  output logic [TOTAL_W-1:0]       total_count,
  output logic [PCOUNT_W-1:0]      priority_count
);

  localparam int AW = $clog2(NUM_PRIORITIES * QUEUE_DEPTH);

  logic              item_valid;
  logic [CMD_W-1:0]  cmd_q;
  logic [TASK_W-1:0] task_q;
  logic [PRI_W-1:0]  pri_q;

  logic              wr_en;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  spq_status_t       stat;
  spq_status_t       res;
  logic              byp_q;
  logic [TASK_W-1:0] byp_task;
  logic [TASK_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      item_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      busy       <= 1'b0;
      item_valid <= start && !busy;
      done       <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q    <= cmd;
    task_q   <= task_id;
    pri_q    <= priority_req;
    res      <= stat;
    byp_q    <= wr_en && (waddr == raddr);
    byp_task <= task_q;
  end

  spq_ctrl #(
    .NUM_PRIORITIES(NUM_PRIORITIES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .valid(item_valid),
    .cmd  (cmd_q),
    .pri  (pri_q),
    .wr_en(wr_en),
    .waddr(waddr),
    .raddr(raddr),
    .stat (stat)
  );

  spq_ram #(
    .WIDTH(TASK_W),
    .DEPTH(NUM_PRIORITIES * QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(task_q),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign status         = res.status;
  assign any_waiting    = res.any_waiting;
  assign front_priority = res.front_priority;
  assign total_count    = res.total_count;
  assign priority_count = res.priority_count;
  assign front_task_id  = !res.any_waiting ? '0 : (byp_q ? byp_task : rdata);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result strobe missing two cycles after transfer");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    done && !any_waiting |-> total_count == '0)
    else $error("nonzero total reported with no task waiting");

endmodule

`default_nettype wire

@@ design/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Per-level head and count registers, command decode, priority encoders and
// store address generation for the strict priority multi-queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
#(
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            valid,
  input  wire logic [CMD_W-1:0]                                cmd,
  input  wire logic [PRI_W-1:0]                                pri,
  output logic                                                 wr_en,
  output logic [$clog2(NUM_PRIORITIES*QUEUE_DEPTH)-1:0]        waddr,
  output logic [$clog2(NUM_PRIORITIES*QUEUE_DEPTH)-1:0]        raddr,
  output spq_status_t                                          stat
);

  localparam int LW    = $clog2(NUM_PRIORITIES);
  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int SW    = HW + 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = NUM_PRIORITIES * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int TW    = $clog2(SLOTS + 1);

  logic [HW-1:0] head       [NUM_PRIORITIES];
  logic [HW-1:0] head_next  [NUM_PRIORITIES];
  logic [CW-1:0] count      [NUM_PRIORITIES];
  logic [CW-1:0] count_next [NUM_PRIORITIES];
  logic [TW-1:0] total;
  logic [TW-1:0] total_next;

  logic          pri_ok;
  logic [LW-1:0] pri_idx;
  logic          pri_full;
  logic [LW-1:0] top;
  logic          top_any;
  logic [LW-1:0] top_n;
  logic          any_n;
  logic          add_ok;
  logic          rem_ok;
  logic [SW-1:0] slot_sum;
  logic [HW-1:0] slot;

  always_comb begin
    pri_ok   = int'(pri) < NUM_PRIORITIES;
    pri_idx  = LW'(pri);
    pri_full = count[pri_idx] == CW'(QUEUE_DEPTH);

    top     = '0;
    top_any = 1'b0;
    for (int k = 0; k < NUM_PRIORITIES; k++) begin
      if (count[k] != '0) begin
        top     = LW'(k);
        top_any = 1'b1;
      end
    end

    add_ok = valid && (cmd == CMD_ADD) && pri_ok && !pri_full;
    rem_ok = valid && (cmd == CMD_REMOVE) && top_any;

    stat.status = ST_OK;
    case (cmd)
      CMD_ADD: begin
        if (!pri_ok || pri_full) begin
          stat.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (!top_any) begin
          stat.status = ST_EMPTY;
        end
      end
      CMD_QUERY: stat.status = ST_OK;
      default:   stat.status = ST_OK;
    endcase

    for (int k = 0; k < NUM_PRIORITIES; k++) begin
      count_next[k] = count[k];
      head_next[k]  = head[k];
      if (add_ok && (pri_idx == LW'(k))) begin
        count_next[k] = count[k] + CW'(1);
      end
      if (rem_ok && (top == LW'(k))) begin
        count_next[k] = count[k] - CW'(1);
        head_next[k]  = (head[k] == HW'(QUEUE_DEPTH - 1)) ? '0 : head[k] + HW'(1);
      end
    end

    total_next = total;
    if (add_ok) begin
      total_next = total + TW'(1);
    end else if (rem_ok) begin
      total_next = total - TW'(1);
    end

    top_n = '0;
    any_n = 1'b0;
    for (int k = 0; k < NUM_PRIORITIES; k++) begin
      if (count_next[k] != '0) begin
        top_n = LW'(k);
        any_n = 1'b1;
      end
    end

    slot_sum = SW'(head[pri_idx]) + SW'(count[pri_idx]);
    slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? HW'(slot_sum - SW'(QUEUE_DEPTH))
                                               : HW'(slot_sum);

    wr_en = add_ok;
    waddr = AW'(AW'(pri_idx) * AW'(QUEUE_DEPTH)) + AW'(slot);
    raddr = AW'(AW'(top_n) * AW'(QUEUE_DEPTH)) + AW'(head_next[top_n]);

    stat.any_waiting    = any_n;
    stat.front_priority = PRI_W'(top_n);
    stat.total_count    = TOTAL_W'(total_next);
    stat.priority_count = pri_ok ? PCOUNT_W'(count_next[pri_idx]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PRIORITIES; k++) begin
        head[k]  <= '0;
        count[k] <= '0;
      end
      total <= '0;
    end else if (valid) begin
      for (int k = 0; k < NUM_PRIORITIES; k++) begin
        head[k]  <= head_next[k];
        count[k] <= count_next[k];
      end
      total <= total_next;
    end
  end

  a_remove_decrements: assert property (@(posedge clk) disable iff (rst)
    rem_ok |=> total == $past(total) - TW'(1))
    else $error("total not decremented after remove");

  a_add_increments: assert property (@(posedge clk) disable iff (rst)
    valid && (cmd == CMD_ADD) && (stat.status == ST_OK) |=> total == $past(total) + TW'(1))
    else $error("total not incremented after accepted add");

endmodule

`default_nettype wire

@@ bench/tb_strict_priority_multi_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strict_priority_multi_queue
// Self-checking bench for the strict priority multi-queue.
// A short table of commands covers the extremes first: empty queue, removes
// on empty, one full level, all levels full, and the spare command code. A
// random mix of add, remove and query bursts follows. Every result is checked
// against the expected report in the table or a behavioral copy of the queues
// kept in the bench. The sender idles at different rates across the run.
// ----------------------------------------------------------------------------

module tb_strict_priority_multi_queue;
  import spq_pkg::*;

  localparam int NPRI      = NUM_PRIORITIES_DEF;
  localparam int QDEPTH    = QUEUE_DEPTH_DEF;
  localparam int N_RANDOM  = 700;
  localparam int STALL_MAX = 1000;
  localparam int N_ROWS    = 19;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                any_waiting;
    logic [TASK_W-1:0]   front_task;
    logic [PRI_W-1:0]    front_pri;
    logic [TOTAL_W-1:0]  total;
    logic [PCOUNT_W-1:0] pcount;
  } queue_report_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TASK_W-1:0] tid;
    logic [PRI_W-1:0]  pri;
    logic [7:0]        reps;
    logic              walk;
    logic              typed;
    queue_report_t     rpt;
  } cmd_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd;
  logic [TASK_W-1:0]   task_id;
  logic [PRI_W-1:0]    priority_req;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic                any_waiting;
  logic [TASK_W-1:0]   front_task_id;
  logic [PRI_W-1:0]    front_priority;
  logic [TOTAL_W-1:0]  total_count;
  logic [PCOUNT_W-1:0] priority_count;

  strict_priority_multi_queue u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .task_id        (task_id),
    .priority_req   (priority_req),
    .done           (done),
    .status         (status),
    .any_waiting    (any_waiting),
    .front_task_id  (front_task_id),
    .front_priority (front_priority),
    .total_count    (total_count),
    .priority_count (priority_count)
  );

  // Shadow copy of the queues
  logic [TASK_W-1:0] slot_mem [NPRI][QDEPTH];
  int                head_ptr [NPRI];
  int                lvl_cnt  [NPRI];
  int                waiting_total;

  queue_report_t report_q [$];
  cmd_row_t      cmd_tab [N_ROWS];

  int sender_idle_pct;
  int mismatches;
  int stall_cycles;
  int n_sent, n_adds, n_removes, n_queries, n_full, n_empty, peak_total;

  always #2 clk = ~clk;

  function automatic int top_level();
    for (int k = NPRI - 1; k >= 0; k--) begin
      if (lvl_cnt[k] != 0) return k;
    end
    return -1;
  endfunction

  function automatic queue_report_t predict_queue_report(input logic [CMD_W-1:0] c,
                                                         input logic [TASK_W-1:0] t,
                                                         input logic [PRI_W-1:0] p);
    queue_report_t r;
    int top;
    r = '0;
    r.status = ST_OK;
    if (c == CMD_ADD) begin
      if (int'(p) >= NPRI || lvl_cnt[p] >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_mem[p][(head_ptr[p] + lvl_cnt[p]) % QDEPTH] = t;
        lvl_cnt[p]++;
        waiting_total++;
      end
    end else if (c == CMD_REMOVE) begin
      top = top_level();
      if (top < 0) begin
        r.status = ST_EMPTY;
      end else begin
        head_ptr[top] = (head_ptr[top] + 1) % QDEPTH;
        lvl_cnt[top]--;
        waiting_total--;
      end
    end
    top = top_level();
    if (top >= 0) begin
      r.any_waiting = 1'b1;
      r.front_task  = slot_mem[top][head_ptr[top]];
      r.front_pri   = PRI_W'(top);
    end
    r.total  = TOTAL_W'(waiting_total);
    r.pcount = (int'(p) < NPRI) ? PCOUNT_W'(lvl_cnt[p]) : '0;
    return r;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [TASK_W-1:0] t,
                          input logic [PRI_W-1:0] p, input logic use_typed,
                          input queue_report_t typed_rpt);
    queue_report_t r;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    cmd          <= c;
    task_id      <= t;
    priority_req <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_queue_report(c, t, p);
    report_q.push_back(use_typed ? typed_rpt : r);
    n_sent++;
    if (c == CMD_ADD) n_adds++;
    else if (c == CMD_REMOVE) n_removes++;
    else n_queries++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
    if (waiting_total > peak_total) peak_total = waiting_total;
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    queue_report_t got, want;
    if (!rst) begin
      if (done === 1'b1) begin
        got = '{status, any_waiting, front_task_id, front_priority, total_count,
                priority_count};
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: unexpected result status=%0d front=%h", $realtime,
                     status, front_task_id);
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR %0t: exp %0d %0d %h %0d %0d %0d, got %0d %0d %h %0d %0d %0d",
                       $realtime, want.status, want.any_waiting, want.front_task,
                       want.front_pri, want.total, want.pcount, got.status,
                       got.any_waiting, got.front_task, got.front_pri, got.total,
                       got.pcount);
          end
        end
      end
      if ((start && !busy) || done === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("Timeout: no transfer for %0d cycles", STALL_MAX);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cmd_row_t row;
    logic [CMD_W-1:0] c;
    logic [TASK_W-1:0] t;
    logic [PRI_W-1:0] p;
    int mode, focus, roll;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_QUERY;
    task_id = '0;
    priority_req = '0;
    mismatches = 0;
    stall_cycles = 0;
    n_sent = 0; n_adds = 0; n_removes = 0; n_queries = 0;
    n_full = 0; n_empty = 0; peak_total = 0;
    waiting_total = 0;
    for (int k = 0; k < NPRI; k++) begin
      head_ptr[k] = 0;
      lvl_cnt[k]  = 0;
    end

    //            cmd         tid       pri   reps  walk  typed  expected
    cmd_tab[0]  = '{CMD_QUERY,  16'h0000, 3'd0, 8'd1,   1'b0, 1'b1,
                    '{ST_OK,    1'b0, 16'h0000, 3'd0, 8'd0,   5'd0}};
    cmd_tab[1]  = '{CMD_REMOVE, 16'h0000, 3'd5, 8'd1,   1'b0, 1'b1,
                    '{ST_EMPTY, 1'b0, 16'h0000, 3'd0, 8'd0,   5'd0}};
    cmd_tab[2]  = '{CMD_SPARE,  16'h0000, 3'd7, 8'd1,   1'b0, 1'b1,
                    '{ST_OK,    1'b0, 16'h0000, 3'd0, 8'd0,   5'd0}};
    cmd_tab[3]  = '{CMD_ADD,    16'hFFFF, 3'd7, 8'd1,   1'b0, 1'b1,
                    '{ST_OK,    1'b1, 16'hFFFF, 3'd7, 8'd1,   5'd1}};
    cmd_tab[4]  = '{CMD_ADD,    16'h0000, 3'd0, 8'd1,   1'b0, 1'b1,
                    '{ST_OK,    1'b1, 16'hFFFF, 3'd7, 8'd2,   5'd1}};
    cmd_tab[5]  = '{CMD_ADD,    16'h5555, 3'd7, 8'd1,   1'b0, 1'b1,
                    '{ST_OK,    1'b1, 16'hFFFF, 3'd7, 8'd3,   5'd2}};
    cmd_tab[6]  = '{CMD_REMOVE, 16'h0000, 3'd7, 8'd1,   1'b0, 1'b0, '0};
    cmd_tab[7]  = '{CMD_REMOVE, 16'h0000, 3'd0, 8'd1,   1'b0, 1'b0, '0};
    cmd_tab[8]  = '{CMD_REMOVE, 16'h0000, 3'd0, 8'd1,   1'b0, 1'b1,
                    '{ST_OK,    1'b0, 16'h0000, 3'd0, 8'd0,   5'd0}};
    cmd_tab[9]  = '{CMD_REMOVE, 16'h0000, 3'd3, 8'd1,   1'b0, 1'b1,
                    '{ST_EMPTY, 1'b0, 16'h0000, 3'd0, 8'd0,   5'd0}};
    cmd_tab[10] = '{CMD_ADD,    16'hAAAA, 3'd3, 8'd16,  1'b0, 1'b0, '0};
    cmd_tab[11] = '{CMD_ADD,    16'h1234, 3'd3, 8'd1,   1'b0, 1'b1,
                    '{ST_FULL,  1'b1, 16'hAAAA, 3'd3, 8'd16,  5'd16}};
    cmd_tab[12] = '{CMD_ADD,    16'hBEEF, 3'd4, 8'd1,   1'b0, 1'b0, '0};
    cmd_tab[13] = '{CMD_SPARE,  16'h0000, 3'd3, 8'd1,   1'b0, 1'b0, '0};
    cmd_tab[14] = '{CMD_REMOVE, 16'h0000, 3'd3, 8'd18,  1'b0, 1'b0, '0};
    cmd_tab[15] = '{CMD_ADD,    16'h8000, 3'd0, 8'd128, 1'b1, 1'b0, '0};
    cmd_tab[16] = '{CMD_ADD,    16'h7777, 3'd2, 8'd1,   1'b0, 1'b1,
                    '{ST_FULL,  1'b1, 16'h8007, 3'd7, 8'd128, 5'd16}};
    cmd_tab[17] = '{CMD_REMOVE, 16'hFFFF, 3'd0, 8'd128, 1'b1, 1'b0, '0};
    cmd_tab[18] = '{CMD_REMOVE, 16'hFFFF, 3'd6, 8'd1,   1'b0, 1'b1,
                    '{ST_EMPTY, 1'b0, 16'h0000, 3'd0, 8'd0,   5'd0}};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 23;
    for (int i = 0; i < N_ROWS; i++) begin
      row = cmd_tab[i];
      for (int k = 0; k < int'(row.reps); k++) begin
        send_cmd(row.cmd, row.tid + TASK_W'(k), row.walk ? row.pri + PRI_W'(k) : row.pri,
                 row.typed, row.rpt);
      end
    end
    drain_results();

    mode = 0;
    focus = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3 || i == 2 * N_RANDOM / 3) begin
        drain_results();
        sender_idle_pct = (i == N_RANDOM / 3) ? 76 : 0;
      end
      // bursts that fill, drain or churn the levels
      if (i % 40 == 0) begin
        mode  = $urandom_range(2);
        focus = $urandom_range(NPRI - 1);
      end
      roll = $urandom_range(99);
      case (mode)
        0: c = (roll < 40) ? CMD_ADD : (roll < 80) ? CMD_REMOVE : CMD_QUERY;
        1: c = (roll < 75) ? CMD_ADD : (roll < 90) ? CMD_REMOVE : CMD_QUERY;
        default: c = (roll < 15) ? CMD_ADD : (roll < 90) ? CMD_REMOVE : CMD_QUERY;
      endcase
      if (c == CMD_QUERY && $urandom_range(1)) c = CMD_SPARE;
      roll = $urandom_range(99);
      t = (roll < 8) ? 16'h0000 : (roll < 16) ? 16'hFFFF : TASK_W'($urandom_range(65535));
      p = ($urandom_range(99) < 50) ? PRI_W'(focus) : PRI_W'($urandom_range(NPRI - 1));
      send_cmd(c, t, p, 1'b0, '0);
    end

    @(negedge clk);
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d transfers: %0d adds (%0d refused full), %0d removes (%0d on empty),",
             n_sent, n_adds, n_full, n_removes, n_empty);
    $display("%0d queries; peak occupancy %0d of %0d slots; %0d mismatches.",
             n_queries, peak_total, NPRI * QDEPTH, mismatches);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/spq_pkg.sv
design/spq_ram.sv
design/spq_ctrl.sv
design/strict_priority_multi_queue.sv
bench/tb_strict_priority_multi_queue.sv
